>>> hdl/gddp_pkg.sv
// Shared types and constants for the padded disk dilation unit.
`timescale 1ns / 1ps

package gddp_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int  CFG_DATA_W = 9;
    localparam int  COORD_W    = 9;
    localparam int  PIXEL_W    = 8;
    localparam int  IDX_W      = 13;

    localparam logic [PIXEL_W-1:0] FULL_COVER = 8'd255;
    localparam logic [PIXEL_W-1:0] PART_COVER = 8'd1;
    localparam logic [PIXEL_W-1:0] NO_COVER   = 8'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic               in_range;
    } t_result;

endpackage

>>> hdl/gddp_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module gddp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/gddp_ctrl.sv
// Command sequencer: pixel writes and disk window scans over the image RAM.
`timescale 1ns / 1ps

module gddp_ctrl #(
    parameter int RADIUS     = 5,
    parameter int CW         = 8,
    parameter int RH         = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [gddp_pkg::COORD_W-1:0]    i_col,
    input  logic [gddp_pkg::COORD_W-1:0]    i_row,
    input  logic [gddp_pkg::PIXEL_W-1:0]    i_pixel,
    input  logic [gddp_pkg::CFG_DATA_W-1:0] i_width,
    input  logic [gddp_pkg::CFG_DATA_W-1:0] i_height,
    input  logic                            i_out_free,
    output logic                            o_done,
    output gddp_pkg::t_result               o_result,
    output logic                            o_mem_en,
    output logic                            o_mem_we,
    output logic [CW+RH-1:0]                o_mem_addr,
    output logic [gddp_pkg::PIXEL_W-1:0]    o_mem_wdata,
    input  logic [gddp_pkg::PIXEL_W-1:0]    i_mem_rdata
);

    localparam logic signed [3:0] RD     = 4'(RADIUS);
    localparam logic signed [3:0] RD_NEG = -4'(RADIUS);
    localparam logic signed [7:0] RR     = 8'(RADIUS * RADIUS);
    localparam logic [9:0]        PAD2   = 10'(2 * RADIUS);

    gddp_pkg::t_state r_state, n_state;

    logic                         r_cmd;
    logic [gddp_pkg::COORD_W-1:0] r_col, r_row;
    logic [gddp_pkg::PIXEL_W-1:0] r_pixel;
    logic signed [3:0]            r_dx, r_dy, n_dx, n_dy;
    logic                         r_tag_vld, r_tag_ctr;
    logic                         r_any, r_full, r_in_range;

    logic                         accept;
    logic                         wr_ok, q_ok;
    logic signed [10:0]           x, y, sx, sy;
    logic                         sx_in, sy_in;
    logic signed [7:0]            sq_x, sq_y, dsq;
    logic                         pos_ok, center, scan_last;
    logic [gddp_pkg::IDX_W-1:0]   wr_col_x, wr_row_x, sc_col_x, sc_row_x;

    function automatic logic [gddp_pkg::IDX_W-1:0] IDX_W_EXT(
        input logic [gddp_pkg::COORD_W-1:0] v
    );
        return gddp_pkg::IDX_W'(v);
    endfunction

    assign accept = i_valid && (r_state == gddp_pkg::S_IDLE);

    assign wr_ok = (r_col < i_width) && (r_row < i_height);
    assign q_ok  = ({1'b0, r_col} < ({1'b0, i_width} + PAD2)) &&
                   ({1'b0, r_row} < ({1'b0, i_height} + PAD2));

    // Padded coordinate back to source frame, then offset by the window position.
    assign x  = $signed({2'b00, r_col}) - $signed(11'(RADIUS));
    assign y  = $signed({2'b00, r_row}) - $signed(11'(RADIUS));
    assign sx = x + $signed({{7{r_dx[3]}}, r_dx});
    assign sy = y + $signed({{7{r_dy[3]}}, r_dy});

    assign sx_in = !sx[10] && (sx[9:0] < {1'b0, i_width});
    assign sy_in = !sy[10] && (sy[9:0] < {1'b0, i_height});

    assign sq_x = $signed({{4{r_dx[3]}}, r_dx}) * $signed({{4{r_dx[3]}}, r_dx});
    assign sq_y = $signed({{4{r_dy[3]}}, r_dy}) * $signed({{4{r_dy[3]}}, r_dy});
    assign dsq  = sq_x + sq_y;

    assign pos_ok    = sx_in && sy_in && (dsq <= RR);
    assign center    = (r_dx == 4'sd0) && (r_dy == 4'sd0);
    assign scan_last = (r_dx == RD) && (r_dy == RD);

    assign wr_col_x = IDX_W_EXT(r_col);
    assign wr_row_x = IDX_W_EXT(r_row);
    assign sc_col_x = gddp_pkg::IDX_W'(sx[9:0]);
    assign sc_row_x = gddp_pkg::IDX_W'(sy[9:0]);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gddp_pkg::S_IDLE: begin
                if (i_valid) n_state = gddp_pkg::S_EXEC;
            end
            gddp_pkg::S_EXEC: begin
                if (r_cmd == gddp_pkg::CMD_QUERY && q_ok) n_state = gddp_pkg::S_SCAN;
                else n_state = gddp_pkg::S_DONE;
            end
            gddp_pkg::S_SCAN: begin
                if (scan_last) n_state = gddp_pkg::S_DRAIN;
            end
            gddp_pkg::S_DRAIN: begin
                n_state = gddp_pkg::S_DONE;
            end
            gddp_pkg::S_DONE: begin
                if (i_out_free) n_state = gddp_pkg::S_IDLE;
            end
            default: n_state = gddp_pkg::S_IDLE;
        endcase
    end

    // Outputs and window counters
    always_comb begin
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = {wr_row_x[RH-1:0], wr_col_x[CW-1:0]};
        o_mem_wdata = r_pixel;
        n_dx        = r_dx;
        n_dy        = r_dy;
        unique case (r_state)
            gddp_pkg::S_EXEC: begin
                o_mem_en = (r_cmd == gddp_pkg::CMD_WRITE) && wr_ok;
                o_mem_we = (r_cmd == gddp_pkg::CMD_WRITE) && wr_ok;
                n_dx     = RD_NEG;
                n_dy     = RD_NEG;
            end
            gddp_pkg::S_SCAN: begin
                o_mem_en   = pos_ok;
                o_mem_addr = {sc_row_x[RH-1:0], sc_col_x[CW-1:0]};
                if (r_dx == RD) begin
                    n_dx = RD_NEG;
                    n_dy = r_dy + 4'sd1;
                end else begin
                    n_dx = r_dx + 4'sd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gddp_pkg::S_IDLE;
            r_tag_vld <= 1'b0;
            r_tag_ctr <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tag_vld <= (r_state == gddp_pkg::S_SCAN) && pos_ok;
            r_tag_ctr <= (r_state == gddp_pkg::S_SCAN) && pos_ok && center;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        if (accept) begin
            r_cmd   <= i_cmd;
            r_col   <= i_col;
            r_row   <= i_row;
            r_pixel <= i_pixel;
        end
        if (r_state == gddp_pkg::S_EXEC) begin
            r_in_range <= (r_cmd == gddp_pkg::CMD_WRITE) ? wr_ok : q_ok;
            r_any      <= 1'b0;
            r_full     <= 1'b0;
        end else begin
            // fold in the registered pixel read for the tagged window position
            if (r_tag_vld && i_mem_rdata != gddp_pkg::NO_COVER) r_any <= 1'b1;
            if (r_tag_ctr && i_mem_rdata == gddp_pkg::FULL_COVER) r_full <= 1'b1;
        end
    end

    assign o_stall = (r_state != gddp_pkg::S_IDLE);
    assign o_done  = (r_state == gddp_pkg::S_DONE);

    always_comb begin
        o_result.in_range = r_in_range;
        o_result.value    = gddp_pkg::NO_COVER;
        if (r_cmd == gddp_pkg::CMD_QUERY && r_in_range) begin
            if (r_full) o_result.value = gddp_pkg::FULL_COVER;
            else if (r_any) o_result.value = gddp_pkg::PART_COVER;
        end
    end

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gddp_pkg::S_SCAN) |-> !o_mem_we)
        else $error("memory write during window scan");

    a_write_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_cmd == gddp_pkg::CMD_WRITE) |-> (o_result.value == gddp_pkg::NO_COVER))
        else $error("write returned nonzero value");

    a_scan_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gddp_pkg::S_SCAN && scan_last) |=> (r_state == gddp_pkg::S_DRAIN))
        else $error("scan did not end in drain");

endmodule

>>> hdl/glyph_disk_dilation_pad_unit.sv
// Padded disk dilation unit: config registers, image RAM, sequencer, output register.
// Sequence: a write passes through EXEC, where it writes the image RAM, and DONE; a query
// inside the padded frame adds a SCAN over every position of the square disk window, with
// an image RAM read where the position lies in disk and image, then DRAIN; an out-of-range query skips SCAN and DRAIN.
// Throughput: one item at a time; the next item is taken while the result waits.
// Reset: synchronous active low; clears control state and sets both dimensions to 256.
// The image RAM is not cleared; every pixel must be written before it is queried.
`timescale 1ns / 1ps

module glyph_disk_dilation_pad_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int RADIUS     = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [gddp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [gddp_pkg::COORD_W-1:0]    i_col,
    input  logic [gddp_pkg::COORD_W-1:0]    i_row,
    input  logic [gddp_pkg::PIXEL_W-1:0]    i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [gddp_pkg::PIXEL_W-1:0]    o_result_value,
    output logic                            o_in_range
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RH    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = CW + RH;
    localparam int DEPTH = 1 << AW;

    localparam logic [gddp_pkg::IDX_W-1:0] MW = gddp_pkg::IDX_W'(MAX_WIDTH);
    localparam logic [gddp_pkg::IDX_W-1:0] MH = gddp_pkg::IDX_W'(MAX_HEIGHT);

    logic [gddp_pkg::CFG_DATA_W-1:0] r_width, r_height;
    logic [gddp_pkg::CFG_DATA_W-1:0] eff_width, eff_height;

    logic                         r_out_valid;
    gddp_pkg::t_result            r_out;
    gddp_pkg::t_result            ctrl_result;
    logic                         out_free, ctrl_done;

    logic                         mem_en, mem_we;
    logic [AW-1:0]                mem_addr;
    logic [gddp_pkg::PIXEL_W-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gddp_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                gddp_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Clamp the configured size to MAX_WIDTH and MAX_HEIGHT.
    assign eff_width  = (gddp_pkg::IDX_W'(r_width) > MW) ?
                        MW[gddp_pkg::CFG_DATA_W-1:0] : r_width;
    assign eff_height = (gddp_pkg::IDX_W'(r_height) > MH) ?
                        MH[gddp_pkg::CFG_DATA_W-1:0] : r_height;

    assign out_free = !r_out_valid || !i_stall;

    gddp_ram #(
        .WIDTH (gddp_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    gddp_ctrl #(
        .RADIUS     (RADIUS),
        .CW         (CW),
        .RH         (RH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pixel     (i_pixel),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_out_free  (out_free),
        .o_done      (ctrl_done),
        .o_result    (ctrl_result),
        .o_mem_en    (mem_en),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    // Output register: load a finished result when the slot is free, drop it on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done && out_free) begin
            r_out <= ctrl_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out.value;
    assign o_in_range     = r_out.in_range;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken while busy");

    a_result_loads_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_done && out_free) |=> o_valid)
        else $error("finished result not presented");

endmodule
